FILE: sv/utde_pkg.sv
// Shared types, constants and small tables for the UTC date to epoch converter.
package utde_pkg;

    // Calendar and epoch constants
    localparam logic [15:0] FIRST_YEAR      = 16'd1970;
    localparam logic [17:0] DAYS_PER_ERA    = 18'd146097;
    localparam logic [19:0] EPOCH_DAY_SHIFT = 20'd719468;
    localparam logic [41:0] MAX_SECS_RESET  = 42'd4102444800;

    // Reciprocals for division by constants (exact over the 16-bit year range)
    localparam logic [17:0] ERA_RECIP   = 18'd167773;  // floor(x/400) = (x*m) >> 26
    localparam int          ERA_SHIFT   = 26;
    localparam logic [16:0] Y25_RECIP   = 17'd83887;   // floor(x/25)  = (x*m) >> 21
    localparam int          Y25_SHIFT   = 21;

    // One input transaction, unpacked
    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [6:0]  centisecond;
    } date_t;

    // Day-count section result handed to the seconds/microseconds stages
    typedef struct packed {
        logic        ok;
        logic [24:0] days;
        logic [16:0] tsec;
        logic [6:0]  centisecond;
    } day_res_t;

    // First day of a March-based month, (153*mp+2)/5
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Days in a calendar month, February follows the leap flag
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        case (m)
            4'd2:    r = leap ? 5'd29 : 5'd28;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   r = 5'd30;
            default: r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/utde_day_calc.sv
// Date checks and civil-to-days conversion, three pipeline stages.
module utde_day_calc
    import utde_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  date_t    in_date,
    output logic     out_valid,
    input  logic     out_ready,
    output day_res_t out_res
);

    // Stage enables: a stage loads when empty or when the next one moves
    logic en_a, en_b, en_c;
    logic vld_a_reg, vld_b_reg, vld_c_reg;

    assign en_c     = !vld_c_reg || out_ready;
    assign en_b     = !vld_b_reg || en_c;
    assign en_a     = !vld_a_reg || en_b;
    assign in_ready = en_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end
        else
        begin
            if (en_a) vld_a_reg <= in_valid;
            if (en_b) vld_b_reg <= vld_a_reg;
            if (en_c) vld_c_reg <= vld_b_reg;
        end
    end

    // Stage A: range checks, shifted year, day of year, time of day, reciprocals
    logic        ok_a_next;
    logic [15:0] ys_a_next;
    logic [3:0]  mp_a;
    logic [8:0]  doy_a_next;
    logic [16:0] tsec_a_next;
    logic [33:0] era_prod_a_next;
    logic [32:0] y25_prod_a_next;

    always_comb
    begin
        ok_a_next = (in_date.year >= FIRST_YEAR) && (in_date.month >= 4'd1) &&
                    (in_date.month <= 4'd12) && (in_date.day != 5'd0) &&
                    (in_date.hour <= 5'd23) && (in_date.minute <= 6'd59) &&
                    (in_date.second <= 6'd59) && (in_date.centisecond <= 7'd99);
        ys_a_next = in_date.year - {15'd0, (in_date.month <= 4'd2)};
        mp_a      = (in_date.month > 4'd2) ? in_date.month - 4'd3 : in_date.month + 4'd9;
        doy_a_next = month_start(mp_a) + {4'd0, in_date.day} - 9'd1;
        tsec_a_next = 17'(in_date.hour) * 17'd3600 + 17'(in_date.minute) * 17'd60 +
                      17'(in_date.second);
        era_prod_a_next = 34'(ys_a_next) * 34'(ERA_RECIP);
        y25_prod_a_next = 33'(in_date.year) * 33'(Y25_RECIP);
    end

    logic        ok_a_reg;
    logic [15:0] year_a_reg;
    logic [15:0] ys_a_reg;
    logic [3:0]  month_a_reg;
    logic [4:0]  day_a_reg;
    logic [8:0]  doy_a_reg;
    logic [16:0] tsec_a_reg;
    logic [6:0]  centi_a_reg;
    logic [33:0] era_prod_a_reg;
    logic [32:0] y25_prod_a_reg;

    always_ff @(posedge clk)
    begin
        if (en_a && in_valid)
        begin
            ok_a_reg       <= ok_a_next;
            year_a_reg     <= in_date.year;
            ys_a_reg       <= ys_a_next;
            month_a_reg    <= in_date.month;
            day_a_reg      <= in_date.day;
            doy_a_reg      <= doy_a_next;
            tsec_a_reg     <= tsec_a_next;
            centi_a_reg    <= in_date.centisecond;
            era_prod_a_reg <= era_prod_a_next;
            y25_prod_a_reg <= y25_prod_a_next;
        end
    end

    // Stage B: era split, leap rule, month length check, day of era
    logic [7:0]  era_b_next;
    logic [15:0] yoe_full;
    logic [8:0]  yoe;
    logic [11:0] q25;
    logic [15:0] r25_full;
    logic        leap_b;
    logic [14:0] yoe_c100;
    logic [17:0] doe_b_next;
    logic        ok_b_next;

    always_comb
    begin
        era_b_next = era_prod_a_reg[ERA_SHIFT +: 8];
        yoe_full   = ys_a_reg - 16'(era_b_next) * 16'd400;
        yoe        = yoe_full[8:0];
        q25        = y25_prod_a_reg[Y25_SHIFT +: 12];
        r25_full   = year_a_reg - 16'(q25) * 16'd25;
        leap_b     = (year_a_reg[1:0] == 2'd0) &&
                     ((r25_full[4:0] != 5'd0) || (year_a_reg[3:0] == 4'd0));
        yoe_c100   = 15'(yoe) * 15'd41;
        doe_b_next = 18'(yoe) * 18'd365 + 18'(yoe[8:2]) - 18'(yoe_c100[14:12]) +
                     18'(doy_a_reg);
        ok_b_next  = ok_a_reg && (day_a_reg <= month_len(month_a_reg, leap_b));
    end

    logic        ok_b_reg;
    logic [7:0]  era_b_reg;
    logic [17:0] doe_b_reg;
    logic [16:0] tsec_b_reg;
    logic [6:0]  centi_b_reg;

    always_ff @(posedge clk)
    begin
        if (en_b && vld_a_reg)
        begin
            ok_b_reg    <= ok_b_next;
            era_b_reg   <= era_b_next;
            doe_b_reg   <= doe_b_next;
            tsec_b_reg  <= tsec_a_reg;
            centi_b_reg <= centi_a_reg;
        end
    end

    // Stage C: days since 1970 from era and day of era
    logic [26:0] days_c_full;

    always_comb
    begin
        days_c_full = 27'(era_b_reg) * 27'(DAYS_PER_ERA) + 27'(doe_b_reg) -
                      27'(EPOCH_DAY_SHIFT);
    end

    day_res_t res_c_reg;

    always_ff @(posedge clk)
    begin
        if (en_c && vld_b_reg)
        begin
            res_c_reg.ok          <= ok_b_reg;
            res_c_reg.days        <= days_c_full[24:0];
            res_c_reg.tsec        <= tsec_b_reg;
            res_c_reg.centisecond <= centi_b_reg;
        end
    end

    assign out_valid = vld_c_reg;
    assign out_res   = res_c_reg;

endmodule

FILE: sv/utc_date_to_epoch_us_top.sv
// Top level: UTC calendar time to microseconds since 1970, seven-stage pipeline.
// Each input transaction moves through stages A to G in order; stage G holds the output register.
// Throughput: one transaction per cycle; each stage holds under back-pressure and
// empty stages keep filling while the output waits.
// The multipliers (era, days*86400, seconds*10^6) set the stage split.
// Reset clears all stage valids and loads the seconds bound with 4102444800.
module utc_date_to_epoch_us_top
    import utde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // year[15:0] month[19:16] day[24:20] hour[29:25] minute[35:30]
    // second[41:36] centisecond[48:42], zero pad above
    input  logic [55:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // micros[61:0], zero pad above
    output logic [63:0] m_tdata,
    // ok[0]
    output logic        m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_wr_en,
    input  logic [41:0] cfg_wr_data
);

    // Seconds bound register
    logic [41:0] max_secs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_secs_reg <= MAX_SECS_RESET;
        else if (cfg_wr_en)
            max_secs_reg <= cfg_wr_data;
    end

    // Unpack the input transaction
    date_t in_date;

    always_comb
    begin
        in_date.year        = s_tdata[15:0];
        in_date.month       = s_tdata[19:16];
        in_date.day         = s_tdata[24:20];
        in_date.hour        = s_tdata[29:25];
        in_date.minute      = s_tdata[35:30];
        in_date.second      = s_tdata[41:36];
        in_date.centisecond = s_tdata[48:42];
    end

    // Date checks and day count
    logic     day_valid;
    logic     day_ready;
    day_res_t day_res;

    utde_day_calc u_day_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_date   (in_date),
        .out_valid (day_valid),
        .out_ready (day_ready),
        .out_res   (day_res)
    );

    // Stage enables for the seconds and microseconds stages
    logic en_d, en_e, en_f, en_g;
    logic vld_d_reg, vld_e_reg, vld_f_reg, vld_g_reg;

    assign en_g      = !vld_g_reg || m_tready;
    assign en_f      = !vld_f_reg || en_g;
    assign en_e      = !vld_e_reg || en_f;
    assign en_d      = !vld_d_reg || en_e;
    assign day_ready = en_d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_d_reg <= 1'b0;
            vld_e_reg <= 1'b0;
            vld_f_reg <= 1'b0;
            vld_g_reg <= 1'b0;
        end
        else
        begin
            if (en_d) vld_d_reg <= day_valid;
            if (en_e) vld_e_reg <= vld_d_reg;
            if (en_f) vld_f_reg <= vld_e_reg;
            if (en_g) vld_g_reg <= vld_f_reg;
        end
    end

    // Stage D: days * 675 (times 128 gives days * 86400)
    logic [34:0] prod_d_reg;
    logic        ok_d_reg;
    logic [16:0] tsec_d_reg;
    logic [6:0]  centi_d_reg;

    always_ff @(posedge clk)
    begin
        if (en_d && day_valid)
        begin
            prod_d_reg  <= 35'(day_res.days) * 35'd675;
            ok_d_reg    <= day_res.ok;
            tsec_d_reg  <= day_res.tsec;
            centi_d_reg <= day_res.centisecond;
        end
    end

    // Stage E: whole seconds and bound check
    logic [41:0] secs_e_next;
    logic [41:0] secs_e_reg;
    logic        ok_e_reg;
    logic [6:0]  centi_e_reg;

    assign secs_e_next = {prod_d_reg, 7'd0} + 42'(tsec_d_reg);

    always_ff @(posedge clk)
    begin
        if (en_e && vld_d_reg)
        begin
            secs_e_reg  <= secs_e_next;
            ok_e_reg    <= ok_d_reg && (secs_e_next < max_secs_reg);
            centi_e_reg <= centi_d_reg;
        end
    end

    // Stage F: seconds * 15625 and centiseconds * 625 (scaled up later)
    logic [55:0] us_prod_f_reg;
    logic [15:0] cent_f_reg;
    logic        ok_f_reg;

    always_ff @(posedge clk)
    begin
        if (en_f && vld_e_reg)
        begin
            us_prod_f_reg <= 56'(secs_e_reg) * 56'd15625;
            cent_f_reg    <= 16'(centi_e_reg) * 16'd625;
            ok_f_reg      <= ok_e_reg;
        end
    end

    // Stage G: final sum into the output register, zero when rejected
    logic [61:0] epoch_g_next;
    logic [61:0] epoch_g_reg;
    logic        ok_g_reg;

    assign epoch_g_next = ok_f_reg ? {us_prod_f_reg, 6'd0} + 62'({cent_f_reg, 4'd0}) : '0;

    always_ff @(posedge clk)
    begin
        if (en_g && vld_f_reg)
        begin
            epoch_g_reg <= epoch_g_next;
            ok_g_reg    <= ok_f_reg;
        end
    end

    assign m_tvalid = vld_g_reg;
    assign m_tdata  = {2'd0, epoch_g_reg};
    assign m_tuser  = ok_g_reg;

endmodule

FILE: sv/utde_checker.sv
// Port-level checks for the UTC date to epoch converter, bound to the top level.
module utde_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tvalid,
    input logic        m_tready
);

    // Hold a stalled result transaction unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed or dropped");

    // Drive zero data on a rejected result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == 64'd0)
        else $error("rejected result carries nonzero data");

    // Keep the pad bits above the 62-bit result clear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[63:62] == 2'd0)
        else $error("result exceeds 62 bits");

    // Accept input whenever the output register is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // Show no result in the cycle after reset
    assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind utc_date_to_epoch_us_top utde_checker u_utde_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
